// ----- sv/ctp_pkg.sv -----
// Shared types and constants for the capacitive touch presence block.
// No dependencies; every other file imports this package.
`default_nettype none

package ctp_pkg;

  localparam int OSC_W          = 16;  // oscillation count field width
  localparam int BASE_OUT_W     = 16;  // baseline field width on the result
  localparam int CFG_W          = 10;  // width of every config register
  localparam int APB_AW         = 4;   // byte address, registers at 4*i
  localparam int APB_DW         = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CFG_W-1:0] QUIET_GAP_RST = 10'd10;
  localparam logic [CFG_W-1:0] HOLD_RST      = 10'd500;
  localparam logic [CFG_W-1:0] QUIET_SAT_RST = 10'd1000;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_CLEAR   = 1'b1;

  typedef enum logic [1:0] {
    CFG_QUIET_GAP     = 2'd0,
    CFG_PRESENCE_HOLD = 2'd1,
    CFG_QUIET_SAT     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] quiet_gap_min;
    logic [CFG_W-1:0] presence_hold;
    logic [CFG_W-1:0] quiet_saturation;
  } cfg_t;

  typedef struct packed {
    logic             req_type;
    logic [OSC_W-1:0] osc_count;
  } req_t;

  typedef struct packed {
    logic                  touched;
    logic                  sensed_channel;
    logic                  presence_active;
    logic [BASE_OUT_W-1:0] channel_baseline;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/ctp_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on ctp_pkg for field widths.
`default_nettype none

interface ctp_req_if
  import ctp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [OSC_W-1:0] osc_count;

  modport source (output valid, req_type, osc_count, input ready);
  modport sink   (input valid, req_type, osc_count, output ready);
endinterface

interface ctp_res_if
  import ctp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  touched;
  logic                  sensed_channel;
  logic                  presence_active;
  logic [BASE_OUT_W-1:0] channel_baseline;

  modport source (output valid, touched, sensed_channel, presence_active,
                  channel_baseline, input ready);
  modport sink   (input valid, touched, sensed_channel, presence_active,
                  channel_baseline, output ready);
endinterface

`default_nettype wire

// ----- sv/capsense_touch_presence.sv -----
// Capacitive touch presence detector, top level.
// Depends on ctp_pkg, ctp_if.sv, ctp_apb_regs and ctp_sense.
// Usage:
//   req  : valid/ready channel, one transfer per measurement count
//          (req_type = 0) or presence-clear request (req_type = 1).
//   res  : valid/ready channel, exactly one result transfer per request.
//   APB  : three 10-bit registers at byte addresses 0, 4, 8 (quiet_gap_min,
//          presence_hold, quiet_saturation). Write only while idle.
// Timing:
//   A request lands in an input register at its transfer edge; the update
//   (one compare/add level) then runs from it into the result register and
//   commits the state, once the result slot is free. res.valid rises as the
//   result register loads. Throughput is one request per cycle while res.ready
//   stays high, set by the single pass between the two registers.
// Stall:
//   With res.ready low the result register holds; the input register still
//   takes one more request, then req.ready drops until the result drains.
// Reset:
//   rst (synchronous) empties both registers, zeroes baselines, presence
//   timer, quiet counter and channel, and loads defaults 10 / 500 / 1000.
`default_nettype none

module capsense_touch_presence
  import ctp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  ctp_req_if.sink                req,
  ctp_res_if.source              res,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;
  req_t in_item;
  logic in_valid;
  res_t result;
  res_t out_item;
  logic out_valid;
  logic out_load;   // result register takes a new value this cycle
  logic fire;       // held request is processed this cycle

  ctp_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ctp_sense #(
    .COUNT_BITS (COUNT_BITS)
  ) u_sense (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (in_item),
    .fire   (fire),
    .result (result)
  );

  // result slot is free when empty or being drained this cycle
  assign out_load  = !out_valid || res.ready;
  assign fire      = in_valid && out_load;
  assign req.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.req_type  <= req.req_type;
      in_item.osc_count <= req.osc_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= result;
    end
  end

  assign res.valid            = out_valid;
  assign res.touched          = out_item.touched;
  assign res.sensed_channel   = out_item.sensed_channel;
  assign res.presence_active  = out_item.presence_active;
  assign res.channel_baseline = out_item.channel_baseline;

endmodule

`default_nettype wire

// ----- sv/ctp_apb_regs.sv -----
// APB register file: quiet gap, presence hold, quiet saturation.
// Depends on ctp_pkg.
`default_nettype none

module ctp_apb_regs
  import ctp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     regs;
  cfg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = cfg_idx_t'(paddr[APB_AW-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.quiet_gap_min    <= QUIET_GAP_RST;
      regs.presence_hold    <= HOLD_RST;
      regs.quiet_saturation <= QUIET_SAT_RST;
    end else if (wr) begin
      unique case (idx)
        CFG_QUIET_GAP:     regs.quiet_gap_min    <= pwdata[CFG_W-1:0];
        CFG_PRESENCE_HOLD: regs.presence_hold    <= pwdata[CFG_W-1:0];
        CFG_QUIET_SAT:     regs.quiet_saturation <= pwdata[CFG_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CFG_QUIET_GAP:     prdata = APB_DW'(regs.quiet_gap_min);
      CFG_PRESENCE_HOLD: prdata = APB_DW'(regs.presence_hold);
      CFG_QUIET_SAT:     prdata = APB_DW'(regs.quiet_saturation);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/ctp_sense.sv -----
// Per-item update: baselines, presence timer, quiet counter, channel select.
// Holds the sensing state; result is combinational from state and item.
// Depends on ctp_pkg.
`default_nettype none

module ctp_sense
  import ctp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire req_t item,
  input  wire logic fire,
  output res_t      result
);

  logic [COUNT_BITS-1:0] baseline [2];
  logic [CFG_W-1:0]      presence_timer;
  logic [CFG_W-1:0]      quiet_count;
  logic                  current_channel;

  logic [CFG_W-1:0]      presence_timer_next;
  logic [CFG_W-1:0]      quiet_count_next;
  logic [COUNT_BITS-1:0] baseline_next;
  logic                  upd_baseline;

  logic                  meas;
  logic [COUNT_BITS-1:0] c;
  logic [COUNT_BITS-1:0] b;
  logic [COUNT_BITS-1:0] th;
  logic [COUNT_BITS:0]   sum;
  logic                  touch;
  logic [CFG_W-1:0]      timer_dec;
  logic [CFG_W:0]        quiet_pre;

  always_comb begin
    meas      = (item.req_type == REQ_MEASURE);
    c         = COUNT_BITS'(item.osc_count);
    b         = baseline[current_channel];
    th        = b - (b >> 1);
    sum       = {1'b0, b} + {1'b0, c};
    touch     = meas && (c != '0) && (c < th);
    upd_baseline  = meas && (c > th);
    baseline_next = upd_baseline ? sum[COUNT_BITS:1] : b;

    timer_dec = (presence_timer != '0) ? presence_timer - 1'b1 : presence_timer;

    if (!meas) begin
      presence_timer_next = '0;
      quiet_count_next    = quiet_count;
      quiet_pre           = '0;
    end else begin
      presence_timer_next = timer_dec;
      // a touch after a long enough quiet run flips presence
      if (touch && (quiet_count > cfg.quiet_gap_min)) begin
        presence_timer_next = (timer_dec != '0) ? '0 : cfg.presence_hold;
      end
      quiet_pre = touch ? '0 : ({1'b0, quiet_count} + 1'b1);
      if (quiet_pre > {1'b0, cfg.quiet_saturation}) begin
        quiet_count_next = cfg.quiet_saturation;
      end else begin
        quiet_count_next = quiet_pre[CFG_W-1:0];
      end
    end

    result.touched          = touch;
    result.sensed_channel   = current_channel;
    result.presence_active  = (presence_timer_next != '0);
    result.channel_baseline = BASE_OUT_W'(baseline_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline[0]     <= '0;
      baseline[1]     <= '0;
      presence_timer  <= '0;
      quiet_count     <= '0;
      current_channel <= 1'b0;
    end else if (fire) begin
      presence_timer <= presence_timer_next;
      quiet_count    <= quiet_count_next;
      if (meas) begin
        current_channel <= ~current_channel;
      end
      if (upd_baseline) begin
        baseline[current_channel] <= baseline_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_capsense_touch_presence.sv -----
// Self-checking testbench for capsense_touch_presence: directed table, then random phases.
// Needs ctp_pkg, the ctp_req_if/ctp_res_if interfaces and the block itself; nothing else.
// Results are checked in order: typed-in values or a touch/baseline/presence model.

module tb_capsense_touch_presence;
  import ctp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 50;
  localparam int DRAIN_CYCLES = 8;       // input and result registers plus margin
  localparam logic [1:0] CFG_UNUSED = 2'd3;  // no register at this index

  // Directed row: request, plus a literal result where one is typed in.
  typedef struct packed {
    logic             rtype;
    logic [OSC_W-1:0] cnt;
    logic             typed;
    res_t             res;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ctp_req_if req ();
  ctp_res_if res ();

  capsense_touch_presence u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: mirrors the block's baselines, timers, channel and registers.
  logic [OSC_W-1:0] base_est [2];
  logic [CFG_W-1:0] hold_timer;
  int               quiet_run;   // kept wide: may sit above a lowered ceiling
  logic             chan_sel;
  cfg_t             shadow_cfg;

  res_t pending_res [$];         // expected results, oldest first
  int   errors;
  int   cycle_cnt;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   quiet_left;              // quiet measurements still wanted before a touch

  // Directed sequence, reset config (gap 10, hold 500, ceiling 1000).
  // Literal results only for the first rows after reset.
  dir_row_t dir_tab [23] = '{
    '{REQ_CLEAR,   16'd0,     1'b1, '{1'b0, 1'b0, 1'b0, 16'd0}},     // clear out of reset
    '{REQ_MEASURE, 16'd0,     1'b1, '{1'b0, 1'b0, 1'b0, 16'd0}},     // ch0 zero count
    '{REQ_MEASURE, 16'd65535, 1'b1, '{1'b0, 1'b1, 1'b0, 16'd32767}}, // ch1 max count
    '{REQ_MEASURE, 16'd65535, 1'b1, '{1'b0, 1'b0, 1'b0, 16'd32767}}, // ch0 max count
    '{REQ_MEASURE, 16'd65535, 1'b0, '0},  // ch1 baseline climbs again
    '{REQ_MEASURE, 16'd16384, 1'b0, '0},  // ch0 exactly at threshold
    '{REQ_MEASURE, 16'd1,     1'b0, '0},  // ch1 touch, quiet run too short
    '{REQ_MEASURE, 16'd0,     1'b0, '0},  // eleven zero counts: quiet run of 11
    '{REQ_MEASURE, 16'd0,     1'b0, '0},
    '{REQ_MEASURE, 16'd0,     1'b0, '0},
    '{REQ_MEASURE, 16'd0,     1'b0, '0},
    '{REQ_MEASURE, 16'd0,     1'b0, '0},
    '{REQ_MEASURE, 16'd0,     1'b0, '0},
    '{REQ_MEASURE, 16'd0,     1'b0, '0},
    '{REQ_MEASURE, 16'd0,     1'b0, '0},
    '{REQ_MEASURE, 16'd0,     1'b0, '0},
    '{REQ_MEASURE, 16'd0,     1'b0, '0},
    '{REQ_MEASURE, 16'd0,     1'b0, '0},
    '{REQ_MEASURE, 16'd24575, 1'b0, '0},  // ch1 one below threshold: presence set
    '{REQ_MEASURE, 16'd16383, 1'b0, '0},  // ch0 touch right after: no toggle
    '{REQ_CLEAR,   16'd4660,  1'b0, '0},  // clear with active presence
    '{REQ_MEASURE, 16'd24577, 1'b0, '0},  // ch1 one above threshold: baseline moves
    '{REQ_MEASURE, 16'd65535, 1'b0, '0}
  };

  // Register settings per random phase; phase 6 is drawn at run time.
  logic [CFG_W-1:0] gap_tab  [PHASES] = '{10'd10,  10'd0, 10'd1023, 10'd2, 10'd3,  10'd0,
                                          10'd0,   10'd5};
  logic [CFG_W-1:0] hold_tab [PHASES] = '{10'd500, 10'd1, 10'd1023, 10'd0, 10'd20, 10'd7,
                                          10'd0,   10'd1023};
  logic [CFG_W-1:0] sat_tab  [PHASES] = '{10'd1000, 10'd1, 10'd1023, 10'd5, 10'd0, 10'd1023,
                                          10'd0,    10'd4};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Overall watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("capsense_touch_presence: mismatch");
      $finish;
    end
  end

  // Result side back-pressure, redrawn every falling edge.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // One touch-sense step on the predictor state; returns the result it causes.
  function automatic res_t sense_step(input req_t rq);
    res_t             o;
    logic             ch;
    logic             hit;
    logic [OSC_W-1:0] b;
    logic [OSC_W-1:0] th;
    logic [OSC_W:0]   sum;
    ch  = chan_sel;
    hit = 1'b0;
    if (rq.req_type == REQ_CLEAR) begin
      // Clear: timer only; channel, baselines and quiet run untouched.
      hold_timer = '0;
    end else begin
      b  = base_est[ch];
      th = b - (b >> 1);              // baseline minus half, half rounded down
      hit = (rq.osc_count != '0) && (rq.osc_count < th);
      if (rq.osc_count > th) begin
        sum = b + rq.osc_count;
        base_est[ch] = sum[OSC_W:1];
      end
      if (hold_timer != '0)
        hold_timer = hold_timer - 1'b1;
      if (hit) begin
        // A touch after a long enough quiet run toggles presence.
        if (quiet_run > int'(shadow_cfg.quiet_gap_min))
          hold_timer = (hold_timer != '0) ? '0 : shadow_cfg.presence_hold;
        quiet_run = 0;
      end else begin
        quiet_run = quiet_run + 1;
      end
      if (quiet_run > int'(shadow_cfg.quiet_saturation))
        quiet_run = int'(shadow_cfg.quiet_saturation);
      chan_sel = ~ch;
    end
    o.touched          = hit;
    o.sensed_channel   = ch;
    o.presence_active  = (hold_timer != '0);
    o.channel_baseline = base_est[ch];
    return o;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Result monitor: every transfer pops and checks the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t unexpected result: expected none, got touched=%0d ch=%0d pres=%0d base=%0d",
                 $time, res.touched, res.sensed_channel, res.presence_active,
                 res.channel_baseline);
        errors++;
      end else begin
        want = pending_res.pop_front();
        check_field("touched", want.touched, res.touched);
        check_field("sensed_channel", want.sensed_channel, res.sensed_channel);
        check_field("presence_active", want.presence_active, res.presence_active);
        check_field("channel_baseline", want.channel_baseline, res.channel_baseline);
      end
    end
  end

  // Offer one request; called and returning at a falling edge. Idle cycles
  // before it carry junk payload with valid low.
  task automatic send_req(input req_t rq, input logic typed, input res_t typed_res);
    res_t predicted;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req.valid     <= 1'b0;
      req.req_type  <= 1'($urandom);
      req.osc_count <= 16'($urandom);
      @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.req_type  <= rq.req_type;
    req.osc_count <= rq.osc_count;
    do @(posedge clk); while (!req.ready);
    // Transfer taken at this edge: predict before any result can come back.
    predicted = sense_step(rq);
    pending_res.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // APB write (setup + access); mirrors the write into the shadow registers.
  task automatic reg_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    logic [APB_DW-1:0] data;
    data    = {22'($urandom), val};  // upper bits are junk, must be dropped
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (cfg_idx_t'(idx))
      CFG_QUIET_GAP:     shadow_cfg.quiet_gap_min    = val;
      CFG_PRESENCE_HOLD: shadow_cfg.presence_hold    = val;
      CFG_QUIET_SAT:     shadow_cfg.quiet_saturation = val;
      default: ;  // unmapped index: ignored by the block
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // APB read of one register, compared with the shadow copy.
  task automatic reg_read_check(input cfg_idx_t idx);
    logic [CFG_W-1:0] want;
    case (idx)
      CFG_QUIET_GAP:     want = shadow_cfg.quiet_gap_min;
      CFG_PRESENCE_HOLD: want = shadow_cfg.presence_hold;
      default:           want = shadow_cfg.quiet_saturation;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(want)) begin
      $display("%0t register %0d readback: expected %0d, got %0d", $time, idx, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Random request aimed at the current channel's threshold. Mostly quiet
  // runs of chosen length ending in a touch, plus clears and raw noise.
  function automatic req_t pick_req();
    req_t             rq;
    logic [OSC_W-1:0] b;
    logic [OSC_W-1:0] th;
    int               pick;
    int               qmax;
    b    = base_est[chan_sel];
    th   = b - (b >> 1);
    pick = $urandom_range(0, 99);
    rq.req_type  = REQ_MEASURE;
    rq.osc_count = 16'($urandom);
    if (pick < 8) begin
      rq.req_type = REQ_CLEAR;
    end else if (pick < 18) begin
      // raw noise: any count
    end else if (quiet_left == 0 && th > 1) begin
      rq.osc_count = 16'($urandom_range(1, th - 1));
      qmax = int'(shadow_cfg.quiet_gap_min) + 2;
      if (qmax > 24)
        qmax = 24;
      quiet_left = $urandom_range(0, qmax);
    end else begin
      case ($urandom_range(0, 3))
        0: rq.osc_count = th;         // on the threshold
        1: rq.osc_count = '0;
        2: rq.osc_count = '1;
        default: rq.osc_count = (th == '1) ? th : 16'($urandom_range(th + 1, 65535));
      endcase
      if (quiet_left != 0)
        quiet_left--;
    end
    return rq;
  endfunction

  initial begin : stim
    req_t rq;
    // All inputs known from time zero, with reset asserted.
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    req.valid     = 1'b0;
    req.req_type  = REQ_MEASURE;
    req.osc_count = '0;
    errors         = 0;
    cycle_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_left     = 0;
    base_est[0]    = '0;
    base_est[1]    = '0;
    hold_timer     = '0;
    quiet_run      = 0;
    chan_sel       = 1'b0;
    shadow_cfg.quiet_gap_min    = QUIET_GAP_RST;
    shadow_cfg.presence_hold    = HOLD_RST;
    shadow_cfg.quiet_saturation = QUIET_SAT_RST;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, no idling, reset register values.
    foreach (dir_tab[i]) begin
      rq.req_type  = dir_tab[i].rtype;
      rq.osc_count = dir_tab[i].cnt;
      send_req(rq, dir_tab[i].typed, dir_tab[i].res);
    end

    // Random phases: block drained before each register update.
    for (int p = 0; p < PHASES; p++) begin
      req.valid <= 1'b0;
      while (pending_res.size() != 0) @(negedge clk);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      if (p == 6) begin
        gap_tab[p]  = 10'($urandom_range(0, 15));
        hold_tab[p] = 10'($urandom_range(1, 40));
        sat_tab[p]  = 10'($urandom_range(1, 30));
      end
      reg_write(CFG_QUIET_GAP, gap_tab[p]);
      reg_write(CFG_PRESENCE_HOLD, hold_tab[p]);
      reg_write(CFG_QUIET_SAT, sat_tab[p]);
      reg_write(CFG_UNUSED, 10'($urandom));
      reg_read_check(CFG_QUIET_GAP);
      reg_read_check(CFG_PRESENCE_HOLD);
      reg_read_check(CFG_QUIET_SAT);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      quiet_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rq = pick_req();
        send_req(rq, 1'b0, '0);
      end
    end

    // Drain, then a short window to catch any stray transfer.
    req.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("capsense_touch_presence: match");
    else
      $display("capsense_touch_presence: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
sv/ctp_pkg.sv
sv/ctp_if.sv
sv/ctp_apb_regs.sv
sv/ctp_sense.sv
sv/capsense_touch_presence.sv
tb/sv/tb_capsense_touch_presence.sv
